// File: rtl/sqlkt_pkg.sv
package sqlkt_pkg;

	// default offset counter width
	localparam int POS_WIDTH_DEF = 16;

	// fixed output field widths
	localparam int OUT_POS_W = 16;

	// lexer modes
	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_DASH,
		MODE_COMMENT,
		MODE_IDENT,
		MODE_DONE
	} lex_mode_t;

	// result kinds (tuser)
	localparam logic RES_TOKEN = 1'b0;
	localparam logic RES_END   = 1'b1;

	// token kinds
	localparam logic [1:0] TOK_IDENT  = 2'd0;
	localparam logic [1:0] TOK_SELECT = 2'd1;
	localparam logic [1:0] TOK_FROM   = 2'd2;
	localparam logic [1:0] TOK_WHERE  = 2'd3;

	// keyword slots in the alive mask
	localparam logic [1:0] KW_SELECT = 2'd0;
	localparam logic [1:0] KW_FROM   = 2'd1;
	localparam logic [1:0] KW_WHERE  = 2'd2;

	localparam logic [2:0] KW_LEN_SELECT = 3'd6;
	localparam logic [2:0] KW_LEN_FROM   = 3'd4;
	localparam logic [2:0] KW_LEN_WHERE  = 3'd5;
	localparam logic [2:0] IDENT_LEN_MAX = 3'd7;

	// characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_US    = 8'h5F;

	// one result word
	typedef struct packed {
		logic                 result_kind;
		logic [1:0]           token_kind;
		logic [OUT_POS_W-1:0] start_pos;
		logic [OUT_POS_W-1:0] end_pos;
		logic                 run_last;
	} result_t;

	// keyword character at position i (lower case)
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] ch;
		ch = 8'h00;
		unique case ({k, i})
			{KW_SELECT, 3'd0}: ch = "s";
			{KW_SELECT, 3'd1}: ch = "e";
			{KW_SELECT, 3'd2}: ch = "l";
			{KW_SELECT, 3'd3}: ch = "e";
			{KW_SELECT, 3'd4}: ch = "c";
			{KW_SELECT, 3'd5}: ch = "t";
			{KW_FROM, 3'd0}:   ch = "f";
			{KW_FROM, 3'd1}:   ch = "r";
			{KW_FROM, 3'd2}:   ch = "o";
			{KW_FROM, 3'd3}:   ch = "m";
			{KW_WHERE, 3'd0}:  ch = "w";
			{KW_WHERE, 3'd1}:  ch = "h";
			{KW_WHERE, 3'd2}:  ch = "e";
			{KW_WHERE, 3'd3}:  ch = "r";
			{KW_WHERE, 3'd4}:  ch = "e";
			default:           ch = 8'h00;
		endcase
		return ch;
	endfunction

	// drop keywords whose prefix no longer matches
	function automatic logic [2:0] kw_match(input logic [7:0] c, input logic [2:0] len,
		input logic [2:0] alive);
		logic [7:0] lc;
		logic [2:0] res;
		lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		res = alive;
		if (len >= KW_LEN_SELECT || kw_char(KW_SELECT, len) != lc)
			res[KW_SELECT] = 1'b0;
		if (len >= KW_LEN_FROM || kw_char(KW_FROM, len) != lc)
			res[KW_FROM] = 1'b0;
		if (len >= KW_LEN_WHERE || kw_char(KW_WHERE, len) != lc)
			res[KW_WHERE] = 1'b0;
		return res;
	endfunction

	// token kind from final match state
	function automatic logic [1:0] kw_kind(input logic [2:0] alive, input logic [2:0] len);
		logic [1:0] kind;
		kind = TOK_IDENT;
		if (alive[KW_SELECT] && len == KW_LEN_SELECT)
			kind = TOK_SELECT;
		else if (alive[KW_FROM] && len == KW_LEN_FROM)
			kind = TOK_FROM;
		else if (alive[KW_WHERE] && len == KW_LEN_WHERE)
			kind = TOK_WHERE;
		return kind;
	endfunction

endpackage

// File: rtl/sql_keyword_tokenizer_unit.sv
// Streaming SQL lexer: one text byte per word, tokens and end marks out.
// Result words are registered in a four-entry result queue when their byte is accepted.
// Throughput: one byte per cycle; a byte yields up to two result words, which leave
// one per cycle while m_tready is high; s_tready drops while more than two wait.
// Reset (arst_n low, asynchronous): lexer returns to whitespace skipping at offset
// zero and the result queue empties.
module sql_keyword_tokenizer_unit #(
	parameter int POS_WIDTH = sqlkt_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] token_kind, [17:2] start_pos, [33:18] end_pos
	output logic        m_tuser,   // result_kind
	output logic        m_tlast    // run_last
);

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);
	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	// lexer state
	sqlkt_pkg::lex_mode_t mode_q, mode_mid, mode_n;
	logic [POS_WIDTH-1:0] pos_q, pos_n, pos_inc;
	logic [POS_WIDTH-1:0] start_q, start_mid, start_n;
	logic [2:0]           alive_q, alive_mid, alive_n;
	logic [2:0]           len_q, len_mid, len_n;

	// character classes
	logic [7:0] ch;
	logic       is_ws, is_dash, is_nl, is_alpha, is_word;
	logic       s_acc, m_acc;

	// result queue
	sqlkt_pkg::result_t rq_q [RQ_DEPTH];
	sqlkt_pkg::result_t res [2];
	logic [1:0]         res_cnt;
	logic [RQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [RQ_CW-1:0]   count_q;

	logic tok_mid, skip_run, end_mid, tok_fin, end_fin;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign ch    = s_tdata;

	// classify incoming byte
	always_comb begin
		is_ws    = (ch == sqlkt_pkg::CH_SPACE) || (ch == sqlkt_pkg::CH_NL);
		is_nl    = (ch == sqlkt_pkg::CH_NL);
		is_dash  = (ch == sqlkt_pkg::CH_DASH);
		is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
			(ch == sqlkt_pkg::CH_US);
		is_word  = is_alpha || (ch >= "0" && ch <= "9");
	end

	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + POS_WIDTH'(1);

	// which steps run for this byte
	assign tok_mid  = (mode_q == sqlkt_pkg::MODE_IDENT) && !is_word;
	assign skip_run = (mode_q == sqlkt_pkg::MODE_SKIP) ||
		((mode_q == sqlkt_pkg::MODE_DASH) && !is_dash) || tok_mid;
	assign end_mid  = skip_run && !is_ws && !is_dash && !is_alpha;
	assign tok_fin  = s_tlast && (mode_mid == sqlkt_pkg::MODE_IDENT);
	assign end_fin  = s_tlast && (mode_mid != sqlkt_pkg::MODE_DONE);

	// next state: byte step, then final-byte restart
	always_comb begin
		mode_mid  = mode_q;
		start_mid = start_q;
		alive_mid = alive_q;
		len_mid   = len_q;
		unique case (mode_q)
			sqlkt_pkg::MODE_COMMENT: begin
				if (is_nl)
					mode_mid = sqlkt_pkg::MODE_SKIP;
			end
			sqlkt_pkg::MODE_DASH: begin
				if (is_dash)
					mode_mid = sqlkt_pkg::MODE_COMMENT;
			end
			sqlkt_pkg::MODE_IDENT: begin
				if (is_word) begin
					alive_mid = sqlkt_pkg::kw_match(ch, len_q, alive_q);
					len_mid   = (len_q == sqlkt_pkg::IDENT_LEN_MAX) ? len_q : len_q + 3'd1;
				end
			end
			default: ;
		endcase
		if (skip_run) begin
			if (is_ws) begin
				mode_mid = sqlkt_pkg::MODE_SKIP;
			end else if (is_dash) begin
				mode_mid = sqlkt_pkg::MODE_DASH;
			end else if (is_alpha) begin
				mode_mid  = sqlkt_pkg::MODE_IDENT;
				start_mid = pos_q;
				alive_mid = sqlkt_pkg::kw_match(ch, 3'd0, 3'b111);
				len_mid   = 3'd1;
			end else begin
				mode_mid = sqlkt_pkg::MODE_DONE;
			end
		end
		if (s_tlast) begin
			mode_n  = sqlkt_pkg::MODE_SKIP;
			pos_n   = '0;
			start_n = '0;
			alive_n = 3'b111;
			len_n   = 3'd0;
		end else begin
			mode_n  = mode_mid;
			pos_n   = pos_inc;
			start_n = start_mid;
			alive_n = alive_mid;
			len_n   = len_mid;
		end
	end

	// results in order: token, end, final token, final end
	always_comb begin
		res[0]  = '0;
		res[1]  = '0;
		res_cnt = 2'd0;
		if (tok_mid) begin
			res[res_cnt[0]].result_kind = sqlkt_pkg::RES_TOKEN;
			res[res_cnt[0]].token_kind  = sqlkt_pkg::kw_kind(alive_q, len_q);
			res[res_cnt[0]].start_pos   = sqlkt_pkg::OUT_POS_W'(start_q);
			res[res_cnt[0]].end_pos     = sqlkt_pkg::OUT_POS_W'(pos_q);
			res_cnt = res_cnt + 2'd1;
		end
		if (end_mid && res_cnt != 2'd2) begin
			res[res_cnt[0]].result_kind = sqlkt_pkg::RES_END;
			res_cnt = res_cnt + 2'd1;
		end
		if (tok_fin && res_cnt != 2'd2) begin
			res[res_cnt[0]].result_kind = sqlkt_pkg::RES_TOKEN;
			res[res_cnt[0]].token_kind  = sqlkt_pkg::kw_kind(alive_mid, len_mid);
			res[res_cnt[0]].start_pos   = sqlkt_pkg::OUT_POS_W'(start_mid);
			res[res_cnt[0]].end_pos     = sqlkt_pkg::OUT_POS_W'(pos_inc);
			res_cnt = res_cnt + 2'd1;
		end
		if (end_fin && res_cnt != 2'd2) begin
			res[res_cnt[0]].result_kind = sqlkt_pkg::RES_END;
			res_cnt = res_cnt + 2'd1;
		end
		if (res_cnt == 2'd1)
			res[0].run_last = 1'b1;
		else if (res_cnt == 2'd2)
			res[1].run_last = 1'b1;
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sqlkt_pkg::MODE_SKIP;
			pos_q   <= '0;
			start_q <= '0;
			alive_q <= 3'b111;
			len_q   <= 3'd0;
		end else if (s_acc) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			alive_q <= alive_n;
			len_q   <= len_n;
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (s_acc && res_cnt != 2'd0)
			rq_q[wr_ptr_q] <= res[0];
		if (s_acc && res_cnt == 2'd2)
			rq_q[wr_ptr_q + RQ_AW'(1)] <= res[1];
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s_acc)
				wr_ptr_q <= wr_ptr_q + RQ_AW'(res_cnt);
			if (m_acc)
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			count_q <= count_q + RQ_CW'(s_acc ? res_cnt : 2'd0) - RQ_CW'(m_acc);
		end
	end

	// two free slots needed per byte
	assign s_tready = (count_q <= RQ_CW'(RQ_DEPTH - 2));
	assign m_tvalid = (count_q != '0);
	assign m_tuser  = rq_q[rd_ptr_q].result_kind;
	assign m_tlast  = rq_q[rd_ptr_q].run_last;
	assign m_tdata  = {6'd0, rq_q[rd_ptr_q].end_pos, rq_q[rd_ptr_q].start_pos,
		rq_q[rd_ptr_q].token_kind};

`ifndef SYNTHESIS
	// queue never holds more than its depth
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

	// a byte is only taken with room for two results
	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> count_q <= RQ_CW'(RQ_DEPTH - 2))
		else $error("byte accepted without queue room");

	// final byte restarts the lexer
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast |=> mode_q == sqlkt_pkg::MODE_SKIP && pos_q == '0)
		else $error("lexer not restarted after final byte");

	// an open text always closes with a pending result
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast && mode_q != sqlkt_pkg::MODE_DONE |=> count_q != '0)
		else $error("final byte left no result");
`endif

endmodule

// File: verif/tb_sql_keyword_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_sql_keyword_tokenizer_unit;
	import sqlkt_pkg::*;

	localparam logic [15:0] POS_CAP      = 16'hFFFF;
	localparam int          RANDOM_BYTES = 1590;
	localparam int          HOLD_CYCLES  = 60;

	// Lexer shadow: predicts token/end words for every accepted text byte
	class token_tracker;
		lex_mode_t   mode;
		logic [15:0] next_pos;
		logic [15:0] word_start;
		logic [47:0] word_bits;
		int          word_len;
		result_t     fresh[$];
		result_t     want_words[$];
		int          errors;
		int          live_bytes;
		int          texts;
		int          tokens;
		int          keywords;
		int          ends;

		function new();
			restart();
			errors     = 0;
			live_bytes = 0;
			texts      = 0;
			tokens     = 0;
			keywords   = 0;
			ends       = 0;
		endfunction

		function void restart();
			mode       = MODE_SKIP;
			next_pos   = '0;
			word_start = '0;
			word_bits  = '0;
			word_len   = 0;
		endfunction

		function bit is_lead(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_US;
		endfunction

		function bit is_word_byte(logic [7:0] b);
			return is_lead(b) || (b >= "0" && b <= "9");
		endfunction

		// count up to seven lower-cased characters of the identifier, keeping the last six
		function void add_char(logic [7:0] b);
			logic [7:0] lc;
			lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			if (word_len < 7) begin
				word_bits = {word_bits[39:0], lc};
				word_len++;
			end
		endfunction

		function void note_end();
			result_t r;
			r = '0;
			r.result_kind = RES_END;
			fresh.insert(fresh.size(), r);
			ends++;
		endfunction

		function void close_word(logic [15:0] stop);
			result_t r;
			r = '0;
			r.result_kind = RES_TOKEN;
			r.token_kind  = TOK_IDENT;
			if (word_len == 6 && word_bits == "select")
				r.token_kind = TOK_SELECT;
			else if (word_len == 4 && word_bits[31:0] == "from")
				r.token_kind = TOK_FROM;
			else if (word_len == 5 && word_bits[39:0] == "where")
				r.token_kind = TOK_WHERE;
			r.start_pos = word_start;
			r.end_pos   = stop;
			fresh.insert(fresh.size(), r);
			tokens++;
			if (r.token_kind != TOK_IDENT)
				keywords++;
		endfunction

		// byte seen while between tokens
		function void lead_byte(logic [7:0] b, logic [15:0] p);
			if (b == CH_SPACE || b == CH_NL) begin
				mode = MODE_SKIP;
			end else if (b == CH_DASH) begin
				mode = MODE_DASH;
			end else if (is_lead(b)) begin
				mode       = MODE_IDENT;
				word_start = p;
				word_bits  = '0;
				word_len   = 0;
				add_char(b);
			end else begin
				note_end();
				mode = MODE_DONE;
			end
		endfunction

		function void take_byte(logic [7:0] b, bit fin);
			logic [15:0] p;
			p = next_pos;
			fresh.delete();
			if (mode != MODE_DONE)
				live_bytes++;
			case (mode)
				MODE_DONE: ;
				MODE_COMMENT: begin
					if (b == CH_NL)
						mode = MODE_SKIP;
				end
				MODE_DASH: begin
					if (b == CH_DASH)
						mode = MODE_COMMENT;
					else
						lead_byte(b, p);
				end
				MODE_IDENT: begin
					if (is_word_byte(b)) begin
						add_char(b);
					end else begin
						close_word(p);
						mode = MODE_SKIP;
						lead_byte(b, p);
					end
				end
				default: lead_byte(b, p);
			endcase
			if (fin) begin
				if (mode == MODE_IDENT)
					close_word((p == POS_CAP) ? p : p + 16'd1);
				if (mode != MODE_DONE)
					note_end();
				restart();
				texts++;
			end else begin
				next_pos = (p == POS_CAP) ? p : p + 16'd1;
			end
			if (fresh.size() > 0)
				fresh[fresh.size()-1].run_last = 1'b1;
			foreach (fresh[i])
				want_words.insert(want_words.size(), fresh[i]);
		endfunction

		function void field_check(string name, logic [15:0] exp, logic [15:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
			end
		endfunction

		function void check_word(logic kind, logic [1:0] tok, logic [15:0] sp,
			logic [15:0] ep, logic last, logic [5:0] pad);
			result_t w;
			if (want_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got kind %0d tok %0d %0d..%0d",
					$time, kind, tok, sp, ep);
				return;
			end
			w = want_words.pop_front();
			field_check("result_kind", 16'(w.result_kind), 16'(kind));
			field_check("token_kind", 16'(w.token_kind), 16'(tok));
			field_check("start_pos", w.start_pos, sp);
			field_check("end_pos", w.end_pos, ep);
			field_check("run_last", 16'(w.run_last), 16'(last));
			field_check("tdata padding", 16'd0, 16'(pad));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	bit hold_req     = 1'b0;

	token_tracker tracker = new();

	sql_keyword_tokenizer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(m_tuser, m_tdata[1:0], m_tdata[17:2], m_tdata[33:18],
				m_tlast, m_tdata[39:34]);
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				n = $urandom_range(1, 9);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#10ms;
		$display("sql_keyword_tokenizer_unit test failed");
		$finish;
	end

	// offer one word, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b, input bit fin);
		int n;
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			n = $urandom_range(1, 9);
			repeat (n) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = fin;
		do @(posedge clk); while (!s_tready);
		tracker.take_byte(b, fin);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic logic [7:0] flip_case(logic [7:0] b);
		if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(0, 1))
			return b ^ 8'h20;
		return b;
	endfunction

	function automatic logic [7:0] bad_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_SPACE || b == CH_NL || b == CH_DASH || tracker.is_word_byte(b));
		return b;
	endfunction

	// keyword, near-miss keyword, or random identifier
	function automatic void add_word(ref logic [7:0] q[$]);
		string alpha;
		string w;
		int    pick;
		int    len;
		alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		pick  = $urandom_range(0, 9);
		case ($urandom_range(0, 2))
			0: w = "select";
			1: w = "from";
			default: w = "where";
		endcase
		if (pick >= 4 && pick <= 5) begin
			if ($urandom_range(0, 1))
				w = w.substr(0, w.len() - 2);
			else
				w = {w, "s"};
		end else if (pick > 5) begin
			len = $urandom_range(1, 9);
			w = "";
			for (int i = 0; i < len; i++)
				w = {w, alpha.substr(0, 0)};
			for (int i = 0; i < len; i++)
				w[i] = alpha[$urandom_range(0, (i == 0) ? 52 : 62)];
		end
		for (int i = 0; i < w.len(); i++)
			q.insert(q.size(), flip_case(w[i]));
	endfunction

	function automatic void add_comment(ref logic [7:0] q[$], input bit close);
		logic [7:0] b;
		int         n;
		q.insert(q.size(), CH_DASH);
		q.insert(q.size(), CH_DASH);
		n = $urandom_range(0, 5);
		repeat (n) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
			q.insert(q.size(), b);
		end
		if (close)
			q.insert(q.size(), CH_NL);
	endfunction

	// mostly well-formed queries, some noise
	function automatic void build_text(ref logic [7:0] q[$]);
		int pieces;
		q.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 6)) q.insert(q.size(), 8'($urandom_range(0, 255)));
			return;
		end
		pieces = $urandom_range(1, 6);
		for (int i = 0; i < pieces; i++) begin
			add_word(q);
			if (i == pieces - 1)
				break;
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 3))
					q.insert(q.size(), $urandom_range(0, 1) ? CH_SPACE : CH_NL);
				3: add_comment(q, 1'b1);
				4: q.insert(q.size(), CH_DASH);
				5: begin
					q.insert(q.size(), CH_SPACE);
					q.insert(q.size(), CH_DASH);
				end
				6: q.insert(q.size(), bad_byte());
				default: q.insert(q.size(), CH_SPACE);
			endcase
		end
		// how the text closes
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5: q.insert(q.size(), CH_SPACE);
			6: add_comment(q, 1'b0);
			7: q.insert(q.size(), CH_DASH);
			8: q.insert(q.size(), bad_byte());
			default: begin
				q.insert(q.size(), bad_byte());
				repeat ($urandom_range(1, 3)) q.insert(q.size(), 8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	initial begin
		logic [7:0] q[$];
		int         done_bytes;
		bit         held;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		held     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed texts
		send_text("SeLeCt _9");
		send_text("Where!");
		send_text("-from--x");
		send_byte(8'h00, 1'b1);
		send_text("\n-");
		send_byte(8'hFF, 1'b0);
		send_byte("b", 1'b1);

		// random queries
		done_bytes = 0;
		while (done_bytes < RANDOM_BYTES) begin
			src_idle_on  = (done_bytes < RANDOM_BYTES * 3 / 4) && $urandom_range(0, 3) != 0;
			sink_idle_on = (done_bytes < RANDOM_BYTES * 3 / 4) && $urandom_range(0, 3) != 0;
			if (!held && done_bytes > RANDOM_BYTES / 3) begin
				// long receiver hold-off while words keep coming
				held        = 1'b1;
				hold_req    = 1'b1;
				src_idle_on = 1'b0;
				send_text("a b c d e f g h i j k l m n o p");
			end
			build_text(q);
			send_bytes(q);
			done_bytes = done_bytes + q.size();
		end

		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (tracker.want_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Lexed %0d texts (%0d live bytes) with stalls on both sides.",
			tracker.texts, tracker.live_bytes);
		$display("Checked %0d token words (%0d keywords) and %0d end words, %0d errors.",
			tracker.tokens, tracker.keywords, tracker.ends, tracker.errors);
		if (tracker.errors == 0 && tracker.want_words.size() == 0)
			$display("sql_keyword_tokenizer_unit test passed");
		else
			$display("sql_keyword_tokenizer_unit test failed");
		$finish;
	end

endmodule
